>>> design/cftp_pkg.sv
// shared widths and transaction types for the circle-from-three-points core
`timescale 1ns / 1ps
package cftp_pkg;

  // coordinate width, signed two's complement
  localparam int COORD_W = 32;
  // bits of the b multiplier operand consumed per pipeline stage
  localparam int MUL_CHUNK = 16;

  // |u|^2 and |v|^2
  localparam int SQ_W = 2 * COORD_W + 1;
  // magnitude of the denominator d
  localparam int DM_W = 2 * COORD_W + 2;
  // magnitude of the numerators nx, ny
  localparam int NM_W = 3 * COORD_W + 2;

  typedef struct packed {
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by_coord;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
  } cftp_in_t;

  typedef struct packed {
    logic        [COORD_W-2:0] radius;
    logic signed [COORD_W-1:0] centre_x;
    logic signed [COORD_W-1:0] centre_y;
    logic                      degenerate;
    logic                      overflow;
  } cftp_out_t;

endpackage

>>> design/cftp_dly.sv
// fixed-depth delay line with a reset valid lane beside the payload
`timescale 1ns / 1ps
module cftp_dly #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             vin,
  input  logic [WIDTH-1:0] din,
  output logic             vout,
  output logic [WIDTH-1:0] dout
);

  if (DEPTH == 0) begin : g_none
    assign vout = vin;
    assign dout = din;
  end else begin : g_line
    logic [DEPTH-1:0] vl;
    logic [WIDTH-1:0] dl [0:DEPTH-1];

    always_ff @(posedge clk) begin
      if (rst) begin
        vl <= '0;
      end else begin
        vl[0] <= vin;
        for (int i = 1; i < DEPTH; i++) begin
          vl[i] <= vl[i-1];
        end
      end
    end

    always_ff @(posedge clk) begin
      dl[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
        dl[i] <= dl[i-1];
      end
    end

    assign vout = vl[DEPTH-1];
    assign dout = dl[DEPTH-1];
  end

endmodule

>>> design/cftp_mul.sv
// pipelined unsigned multiplier, one chunk of the b operand per stage
`timescale 1ns / 1ps
module cftp_mul #(
  parameter int WA    = 8,
  parameter int WB    = 8,
  parameter int CHUNK = cftp_pkg::MUL_CHUNK
) (
  input  logic            clk,
  input  logic [WA-1:0]   a,
  input  logic [WB-1:0]   b,
  output logic [WA+WB-1:0] p
);

  localparam int NCH  = (WB + CHUNK - 1) / CHUNK;
  localparam int BP_W = NCH * CHUNK;
  localparam int AC_W = WA + BP_W;

  logic [BP_W-1:0] b_pad;
  logic [WA-1:0]   a_s [0:NCH-1];
  logic [BP_W-1:0] b_s [0:NCH-1];
  logic [AC_W-1:0] acc [0:NCH-1];

  assign b_pad = BP_W'(b);

  always_ff @(posedge clk) begin
    a_s[0] <= a;
    b_s[0] <= b_pad;
    acc[0] <= AC_W'(a) * AC_W'(b_pad[CHUNK-1:0]);
  end

  for (genvar k = 1; k < NCH; k++) begin : g_stage
    always_ff @(posedge clk) begin
      a_s[k] <= a_s[k-1];
      b_s[k] <= b_s[k-1];
      acc[k] <= acc[k-1] +
                ((AC_W'(a_s[k-1]) * AC_W'(b_s[k-1][k*CHUNK +: CHUNK])) << (k * CHUNK));
    end
  end

  assign p = acc[NCH-1][WA+WB-1:0];

endmodule

>>> design/cftp_div.sv
// pipelined restoring divider for one centre coordinate, rounding and saturation
`timescale 1ns / 1ps
module cftp_div (
  input  logic                                 clk,
  input  logic [cftp_pkg::NM_W-1:0]            nmag,
  input  logic                                 nneg,
  input  logic [cftp_pkg::DM_W-1:0]            dmag,
  input  logic                                 dneg,
  input  logic signed [cftp_pkg::COORD_W-1:0]  base,
  output logic signed [cftp_pkg::COORD_W-1:0]  cen,
  output logic                                 ovf
);

  localparam int W    = cftp_pkg::COORD_W;
  localparam int K    = W + 2;
  localparam int RD_W = 3 * W + 6;
  localparam int DV_W = cftp_pkg::DM_W + 1;

  logic [RD_W-1:0] rem0_c;
  logic [RD_W-1:0] dv0_c;
  logic            big_c;

  logic [RD_W-1:0]       rem [0:K];
  logic [DV_W-1:0]       dv  [0:K];
  logic [K-1:0]          q   [0:K];
  logic                  big [0:K];
  logic                  qn  [0:K];
  logic signed [W-1:0]   bs  [0:K];

  logic signed [W+3:0] qs;
  logic signed [W+3:0] sum;
  logic                out_of_range;

  // rounding to nearest: (2n + d) / 2d
  always_comb begin
    rem0_c = (RD_W'(nmag) << 1) + RD_W'(dmag);
    dv0_c  = RD_W'(dmag) << 1;
    big_c  = rem0_c >= (dv0_c << K);
  end

  always_ff @(posedge clk) begin
    rem[0] <= rem0_c;
    dv[0]  <= DV_W'(dv0_c);
    q[0]   <= '0;
    big[0] <= big_c;
    qn[0]  <= nneg ^ dneg;
    bs[0]  <= base;
  end

  for (genvar s = 1; s <= K; s++) begin : g_step
    localparam int I = K - s;
    logic [RD_W-1:0] sub;
    assign sub = RD_W'(dv[s-1]) << I;

    always_ff @(posedge clk) begin
      if (rem[s-1] >= sub) begin
        rem[s] <= rem[s-1] - sub;
        q[s]   <= q[s-1] | (K'(1) << I);
      end else begin
        rem[s] <= rem[s-1];
        q[s]   <= q[s-1];
      end
      dv[s]  <= dv[s-1];
      big[s] <= big[s-1];
      qn[s]  <= qn[s-1];
      bs[s]  <= bs[s-1];
    end
  end

  always_comb begin
    qs = $signed({2'b00, q[K]});
    if (qn[K]) begin
      qs = -qs;
    end
    sum = (W+4)'(bs[K]) + qs;
    out_of_range = (sum[W+3:W-1] != '0) && (sum[W+3:W-1] != '1);
  end

  always_ff @(posedge clk) begin
    if (big[K]) begin
      ovf <= 1'b1;
      cen <= qn[K] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else if (out_of_range) begin
      ovf <= 1'b1;
      cen <= sum[W+3] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else begin
      ovf <= 1'b0;
      cen <= sum[W-1:0];
    end
  end

endmodule

>>> design/circle_from_three_points_core.sv
// top level: circumcircle of three points, fully pipelined
`timescale 1ns / 1ps
//
//  channel   | direction | handshake           | payload
//  ----------+-----------+---------------------+-----------------------------------
//  command   | in        | start, busy         | pts : ax ay bx by_coord cx cy
//  result    | out       | done (1-cycle pulse)| res : radius centre_x centre_y
//            |           |                     |       degenerate overflow
//
//  one transaction per cycle; busy is low whenever reset is low
//  latency is set by the chunked multipliers and the 32-step root
//  every stage advances each cycle, results leave as a one-cycle done pulse
//  synchronous reset clears all valid bits; data registers are not reset
//
module circle_from_three_points_core #(
  parameter int MUL_CHUNK = cftp_pkg::MUL_CHUNK
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  cftp_pkg::cftp_in_t  pts,
  output logic                done,
  output cftp_pkg::cftp_out_t res
);

  localparam int W     = cftp_pkg::COORD_W;
  localparam int SQ_W  = cftp_pkg::SQ_W;
  localparam int DM_W  = cftp_pkg::DM_W;
  localparam int NM_W  = cftp_pkg::NM_W;
  localparam int PR_W  = W + SQ_W;          // numerator partial products
  localparam int BIG_W = 6 * W + 6;         // root remainder and trial value
  localparam int DSQ_W = 4 * W + 4;         // d squared
  localparam int ACC_W = 5 * W + 4;         // root times d squared
  localparam int L1    = (W + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int L3    = (NM_W + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int CDLY  = L3 - 2;            // centre path is shorter than the root

  // side data that rides along the first multiplier stages
  typedef struct packed {
    logic                ux_s;
    logic                uy_s;
    logic                vx_s;
    logic                vy_s;
    logic [W-1:0]        ux_m;
    logic [W-1:0]        uy_m;
    logic [W-1:0]        vx_m;
    logic [W-1:0]        vy_m;
    logic signed [W-1:0] ax;
    logic signed [W-1:0] ay;
  } side_a_t;

  typedef struct packed {
    logic [DM_W-1:0]     dm;
    logic                dn;
    logic                dz;
    logic                ux_s;
    logic                uy_s;
    logic                vx_s;
    logic                vy_s;
    logic signed [W-1:0] ax;
    logic signed [W-1:0] ay;
  } side_b_t;

  typedef struct packed {
    logic signed [W-1:0] cx;
    logic                ox;
    logic signed [W-1:0] cy;
    logic                oy;
  } cen_t;

  // never stalls; only hold commands off while in reset
  assign busy = rst;

  // ---------------------------------------------------------------- stage 1
  // differences u = B - A and v = C - A
  logic                v1;
  logic signed [W:0]   ux1, uy1, vx1, vy1;
  logic signed [W-1:0] ax1, ay1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    ux1 <= (W+1)'(pts.bx)       - (W+1)'(pts.ax);
    uy1 <= (W+1)'(pts.by_coord) - (W+1)'(pts.ay);
    vx1 <= (W+1)'(pts.cx)       - (W+1)'(pts.ax);
    vy1 <= (W+1)'(pts.cy)       - (W+1)'(pts.ay);
    ax1 <= pts.ax;
    ay1 <= pts.ay;
  end

  // ---------------------------------------------------------------- stage 2
  // sign and magnitude, the multipliers are unsigned
  logic    v2;
  side_a_t sa2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    sa2.ux_s <= ux1[W];
    sa2.uy_s <= uy1[W];
    sa2.vx_s <= vx1[W];
    sa2.vy_s <= vy1[W];
    sa2.ux_m <= ux1[W] ? W'(-ux1) : W'(ux1);
    sa2.uy_m <= uy1[W] ? W'(-uy1) : W'(uy1);
    sa2.vx_m <= vx1[W] ? W'(-vx1) : W'(vx1);
    sa2.vy_m <= vy1[W] ? W'(-vy1) : W'(vy1);
    sa2.ax   <= ax1;
    sa2.ay   <= ay1;
  end

  // ---------------------------------------------------------------- multiplier bank 1
  // squares of the offsets and the two cross terms of the determinant
  logic [2*W-1:0] p_uxux, p_uyuy, p_vxvx, p_vyvy, p_uxvy, p_uyvx;
  logic           v3;
  side_a_t        sa3;

  cftp_mul #(.WA(W), .WB(W), .CHUNK(MUL_CHUNK)) u_mul_uxux (
    .clk(clk), .a(sa2.ux_m), .b(sa2.ux_m), .p(p_uxux));
  cftp_mul #(.WA(W), .WB(W), .CHUNK(MUL_CHUNK)) u_mul_uyuy (
    .clk(clk), .a(sa2.uy_m), .b(sa2.uy_m), .p(p_uyuy));
  cftp_mul #(.WA(W), .WB(W), .CHUNK(MUL_CHUNK)) u_mul_vxvx (
    .clk(clk), .a(sa2.vx_m), .b(sa2.vx_m), .p(p_vxvx));
  cftp_mul #(.WA(W), .WB(W), .CHUNK(MUL_CHUNK)) u_mul_vyvy (
    .clk(clk), .a(sa2.vy_m), .b(sa2.vy_m), .p(p_vyvy));
  cftp_mul #(.WA(W), .WB(W), .CHUNK(MUL_CHUNK)) u_mul_uxvy (
    .clk(clk), .a(sa2.ux_m), .b(sa2.vy_m), .p(p_uxvy));
  cftp_mul #(.WA(W), .WB(W), .CHUNK(MUL_CHUNK)) u_mul_uyvx (
    .clk(clk), .a(sa2.uy_m), .b(sa2.vx_m), .p(p_uyvx));

  cftp_dly #(.WIDTH($bits(side_a_t)), .DEPTH(L1)) u_dly_a (
    .clk(clk), .rst(rst), .vin(v2), .din(sa2), .vout(v3), .dout(sa3));

  // ---------------------------------------------------------------- stage 4
  // d = 2 (ux vy - uy vx), |u|^2, |v|^2
  logic                  v4;
  side_a_t               sa4;
  logic signed [2*W+1:0] t_a, t_b, dd;
  logic signed [2*W+2:0] d4;
  logic [SQ_W-1:0]       su4, sv4;

  always_comb begin
    t_a = $signed({2'b00, p_uxvy});
    t_b = $signed({2'b00, p_uyvx});
    if (sa3.ux_s ^ sa3.vy_s) begin
      t_a = -t_a;
    end
    if (sa3.uy_s ^ sa3.vx_s) begin
      t_b = -t_b;
    end
    dd = t_a - t_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    d4  <= {dd, 1'b0};
    su4 <= SQ_W'(p_uxux) + SQ_W'(p_uyuy);
    sv4 <= SQ_W'(p_vxvx) + SQ_W'(p_vyvy);
    sa4 <= sa3;
  end

  // ---------------------------------------------------------------- stage 5
  // |d|, its sign and the collinear flag
  logic            v5;
  side_a_t         sa5;
  logic [DM_W-1:0] dm5;
  logic            dn5, dz5;
  logic [SQ_W-1:0] su5, sv5;
  side_b_t         sb5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    dm5 <= d4[2*W+2] ? DM_W'(-d4) : DM_W'(d4);
    dn5 <= d4[2*W+2];
    dz5 <= (d4 == '0);
    su5 <= su4;
    sv5 <= sv4;
    sa5 <= sa4;
  end

  always_comb begin
    sb5.dm   = dm5;
    sb5.dn   = dn5;
    sb5.dz   = dz5;
    sb5.ux_s = sa5.ux_s;
    sb5.uy_s = sa5.uy_s;
    sb5.vx_s = sa5.vx_s;
    sb5.vy_s = sa5.vy_s;
    sb5.ax   = sa5.ax;
    sb5.ay   = sa5.ay;
  end

  // ---------------------------------------------------------------- multiplier bank 2
  // numerator terms vy |u|^2, uy |v|^2, ux |v|^2, vx |u|^2
  logic [PR_W-1:0] p_vysu, p_uysv, p_uxsv, p_vxsu;
  logic            v6d;
  side_b_t         sb6;

  cftp_mul #(.WA(SQ_W), .WB(W), .CHUNK(MUL_CHUNK)) u_mul_vysu (
    .clk(clk), .a(su5), .b(sa5.vy_m), .p(p_vysu));
  cftp_mul #(.WA(SQ_W), .WB(W), .CHUNK(MUL_CHUNK)) u_mul_uysv (
    .clk(clk), .a(sv5), .b(sa5.uy_m), .p(p_uysv));
  cftp_mul #(.WA(SQ_W), .WB(W), .CHUNK(MUL_CHUNK)) u_mul_uxsv (
    .clk(clk), .a(sv5), .b(sa5.ux_m), .p(p_uxsv));
  cftp_mul #(.WA(SQ_W), .WB(W), .CHUNK(MUL_CHUNK)) u_mul_vxsu (
    .clk(clk), .a(su5), .b(sa5.vx_m), .p(p_vxsu));

  cftp_dly #(.WIDTH($bits(side_b_t)), .DEPTH(L1)) u_dly_b (
    .clk(clk), .rst(rst), .vin(v5), .din(sb5), .vout(v6d), .dout(sb6));

  // ---------------------------------------------------------------- stage 6
  // signed numerators nx and ny
  logic                 v6;
  side_b_t              sb6r;
  logic signed [PR_W+1:0] n_a, n_b, n_c, n_d;
  logic signed [PR_W+1:0] nx6, ny6;

  always_comb begin
    n_a = $signed({2'b00, p_vysu});
    n_b = $signed({2'b00, p_uysv});
    n_c = $signed({2'b00, p_uxsv});
    n_d = $signed({2'b00, p_vxsu});
    if (sb6.vy_s) begin
      n_a = -n_a;
    end
    if (sb6.uy_s) begin
      n_b = -n_b;
    end
    if (sb6.ux_s) begin
      n_c = -n_c;
    end
    if (sb6.vx_s) begin
      n_d = -n_d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else begin
      v6 <= v6d;
    end
  end

  always_ff @(posedge clk) begin
    nx6  <= n_a - n_b;
    ny6  <= n_c - n_d;
    sb6r <= sb6;
  end

  // ---------------------------------------------------------------- stage 7
  // numerator magnitudes; the centre dividers and the radius squares fork here
  logic                v7;
  logic [NM_W-1:0]     nmx7, nmy7;
  logic                nnx7, nny7;
  logic [DM_W-1:0]     dm7;
  logic                dn7, dz7;
  logic signed [W-1:0] ax7, ay7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else begin
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    nmx7 <= nx6[PR_W+1] ? NM_W'(-nx6) : NM_W'(nx6);
    nmy7 <= ny6[PR_W+1] ? NM_W'(-ny6) : NM_W'(ny6);
    nnx7 <= nx6[PR_W+1];
    nny7 <= ny6[PR_W+1];
    dm7  <= sb6r.dm;
    dn7  <= sb6r.dn;
    dz7  <= sb6r.dz;
    ax7  <= sb6r.ax;
    ay7  <= sb6r.ay;
  end

  // ---------------------------------------------------------------- centre path
  // round(n / d) added to the first point, saturated
  cen_t cen_c, cen_d;
  logic cen_vd;

  cftp_div u_div_x (
    .clk(clk), .nmag(nmx7), .nneg(nnx7), .dmag(dm7), .dneg(dn7), .base(ax7),
    .cen(cen_c.cx), .ovf(cen_c.ox));

  cftp_div u_div_y (
    .clk(clk), .nmag(nmy7), .nneg(nny7), .dmag(dm7), .dneg(dn7), .base(ay7),
    .cen(cen_c.cy), .ovf(cen_c.oy));

  // line the centres up with the radius; no valid needed on this branch
  cftp_dly #(.WIDTH($bits(cen_t)), .DEPTH(CDLY)) u_dly_cen (
    .clk(clk), .rst(rst), .vin(1'b0), .din(cen_c), .vout(cen_vd), .dout(cen_d));

  // ---------------------------------------------------------------- radius squares
  // nx^2, ny^2 and d^2; d^2 uses the same chunk count so all three line up
  logic [2*NM_W-1:0]      sq_x, sq_y;
  logic [DM_W+NM_W-1:0]   sq_d;
  logic                   v8d, dz8d;

  cftp_mul #(.WA(NM_W), .WB(NM_W), .CHUNK(MUL_CHUNK)) u_mul_nxnx (
    .clk(clk), .a(nmx7), .b(nmx7), .p(sq_x));
  cftp_mul #(.WA(NM_W), .WB(NM_W), .CHUNK(MUL_CHUNK)) u_mul_nyny (
    .clk(clk), .a(nmy7), .b(nmy7), .p(sq_y));
  cftp_mul #(.WA(DM_W), .WB(NM_W), .CHUNK(MUL_CHUNK)) u_mul_dd (
    .clk(clk), .a(dm7), .b(NM_W'(dm7)), .p(sq_d));

  cftp_dly #(.WIDTH(1), .DEPTH(L3)) u_dly_c (
    .clk(clk), .rst(rst), .vin(v7), .din(dz7), .vout(v8d), .dout(dz8d));

  // ---------------------------------------------------------------- root pipeline
  // find the largest r with (r |d|)^2 <= nx^2 + ny^2, one bit per stage:
  //   e = remainder N - r^2 D, pa = r D, trial for bit b = pa 2^(b+1) + D 2^(2b)
  //   bit W-1 set means the radius does not fit and saturates
  logic [BIG_W-1:0] e  [0:W];
  logic [ACC_W-1:0] pa [0:W];
  logic [DSQ_W-1:0] ds [0:W];
  logic [W-1:0]     rr [0:W];
  logic             vq [0:W];
  logic             zq [0:W];

  always_ff @(posedge clk) begin
    if (rst) begin
      vq[0] <= 1'b0;
    end else begin
      vq[0] <= v8d;
    end
  end

  always_ff @(posedge clk) begin
    e[0]  <= BIG_W'(sq_x) + BIG_W'(sq_y);
    ds[0] <= DSQ_W'(sq_d);
    pa[0] <= '0;
    rr[0] <= '0;
    zq[0] <= dz8d;
  end

  for (genvar j = 1; j <= W; j++) begin : g_root
    localparam int B = W - j;
    logic [BIG_W-1:0] trial;

    assign trial = (BIG_W'(pa[j-1]) << (B + 1)) + (BIG_W'(ds[j-1]) << (2 * B));

    always_ff @(posedge clk) begin
      if (rst) begin
        vq[j] <= 1'b0;
      end else begin
        vq[j] <= vq[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (e[j-1] >= trial) begin
        e[j]  <= e[j-1] - trial;
        pa[j] <= pa[j-1] + (ACC_W'(ds[j-1]) << B);
        rr[j] <= rr[j-1] | (W'(1) << B);
      end else begin
        e[j]  <= e[j-1];
        pa[j] <= pa[j-1];
        rr[j] <= rr[j-1];
      end
      ds[j] <= ds[j-1];
      zq[j] <= zq[j-1];
    end
  end

  // ---------------------------------------------------------------- stage 9
  // radius saturation
  logic         v9, dz9, rovf9;
  logic [W-2:0] rad9;

  always_ff @(posedge clk) begin
    if (rst) begin
      v9 <= 1'b0;
    end else begin
      v9 <= vq[W];
    end
  end

  always_ff @(posedge clk) begin
    rovf9 <= rr[W][W-1];
    rad9  <= rr[W][W-1] ? '1 : rr[W][W-2:0];
    dz9   <= zq[W];
  end

  // ---------------------------------------------------------------- output register
  // collinear points force every field but the flag to zero
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v9;
    end
  end

  always_ff @(posedge clk) begin
    if (dz9) begin
      res.radius     <= '0;
      res.centre_x   <= '0;
      res.centre_y   <= '0;
      res.degenerate <= 1'b1;
      res.overflow   <= 1'b0;
    end else begin
      res.radius     <= rad9;
      res.centre_x   <= cen_d.cx;
      res.centre_y   <= cen_d.cy;
      res.degenerate <= 1'b0;
      res.overflow   <= rovf9 | cen_d.ox | cen_d.oy | cen_vd;
    end
  end

endmodule

>>> design/cftp_chk.sv
// port-level checks for the circle-from-three-points core, bound to the top level
`timescale 1ns / 1ps
module cftp_chk (
  input logic                clk,
  input logic                rst,
  input logic                busy,
  input logic                done,
  input cftp_pkg::cftp_out_t res
);

  // no result can come out of a pipeline that reset just flushed
  a_flush: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe right after reset");

  // the pipeline never refuses a transaction outside reset
  a_busy: assert property (@(posedge clk) !rst |-> !busy)
    else $error("busy outside reset");

  // collinear result carries nothing but the flag
  a_degen: assert property (@(posedge clk) disable iff (rst)
    done && res.degenerate |-> res.radius == '0 && res.centre_x == '0 &&
                               res.centre_y == '0 && !res.overflow)
    else $error("degenerate result with nonzero fields");

endmodule

bind circle_from_three_points_core cftp_chk u_cftp_chk (
  .clk(clk),
  .rst(rst),
  .busy(busy),
  .done(done),
  .res(res)
);
